// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and codes for the priority interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int LINE_W = 8;
  localparam int PRIO_W = 8;
  localparam logic [31:0] ID_VALUE = 32'h0031_C011;

  // Request commands
  localparam logic [1:0] CMD_LEVEL = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register selects
  localparam logic [2:0] REG_ID       = 3'd0;
  localparam logic [2:0] REG_FIQ_STAT = 3'd1;
  localparam logic [2:0] REG_IRQ_STAT = 3'd2;
  localparam logic [2:0] REG_CUR_IRQ  = 3'd3;
  localparam logic [2:0] REG_CUR_FIQ  = 3'd4;
  localparam logic [2:0] REG_IRQ_ACK  = 3'd5;
  localparam logic [2:0] REG_FIQ_ACK  = 3'd6;
  localparam logic [2:0] REG_LINE_CFG = 3'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CFGRD,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Line table access: one write address, one read address per cycle
  typedef struct packed {
    logic              act_we;
    logic              cfg_we;
    logic [LINE_W-1:0] waddr;
    logic              act_wdata;
    logic              fast_wdata;
    logic [PRIO_W-1:0] prio_wdata;
    logic [LINE_W-1:0] raddr;
  } tbl_req_t;

  // Registered read data of one line entry
  typedef struct packed {
    logic              active;
    logic              fast;
    logic [PRIO_W-1:0] prio;
  } tbl_rd_t;

endpackage

// ===== rtl/priority_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// Two-class (IRQ/FIQ) vectored interrupt controller with per-line priority.
// ----------------------------------------------------------------------------
// Usage:
//   One request enters on the s_ channel: a line level event, a register
//   read or a register write. Every request gives exactly one response on
//   the m_ channel with the read data, the access error flag and the IRQ and
//   FIQ request levels as they stand after the request.
//   Level events and writes rescan the whole line table through the single
//   read port of the table memories, one line per cycle, for both classes
//   at once. Reads do not rescan the table.
//   Requests are handled one at a time; s_tready is high only while idle.
//   The response sits in an output register; if the receiver stalls, the
//   next request is still taken and runs up to its response, which then
//   waits until the output register is free.
//   After reset a clearing pass writes every table entry to zero, one line
//   per cycle; no request is taken during it.
// ----------------------------------------------------------------------------
module priority_interrupt_controller #(
  parameter int NUM_LINES = 170,
  parameter int PRIO_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] line_index, [8] line_level, [16:9] write_priority, [17] write_fiq,
  // [18] write_ack_nonzero, [23:19] zero
  input  logic [23:0] s_tdata,
  // [1:0] command, [4:2] reg_select
  input  logic [4:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_line, [8] unread_flag, [9] not_acked_flag, [17:10] read_priority,
  // [18] read_fiq, [50:19] id_word, [51] irq_request, [52] fiq_request,
  // [53] bad_access, [55:54] zero
  output logic [55:0] m_tdata
);
  import pic_pkg::*;

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  state_t state, state_next;

  // Latched request
  logic [1:0]        cmd;
  logic [2:0]        regsel;
  logic [LINE_W-1:0] line;
  logic              level;
  logic [PRIO_W-1:0] wprio;
  logic              wfiq;
  logic              acknz;
  logic              line_ok;

  // Controller state
  logic [LINE_W-1:0] irq_winner;
  logic [LINE_W-1:0] fiq_winner;
  logic              irq_locked;
  logic              fiq_locked;
  logic              scan_pend;

  // Scan sequencing
  logic [IDX_W-1:0]  cnt;
  logic              cnt_last;
  logic              pv;
  logic [LINE_W-1:0] pidx;

  // Response fields
  logic [LINE_W-1:0] r_line;
  logic              r_unread;
  logic              r_notack;
  logic [PRIO_W-1:0] r_prio;
  logic              r_fiq;
  logic [31:0]       r_id;
  logic              r_bad;

  tbl_req_t          treq;
  tbl_rd_t           trd;
  logic [LINE_W-1:0] irq_best;
  logic [LINE_W-1:0] fiq_best;
  logic [LINE_W-1:0] irq_win_n;
  logic [LINE_W-1:0] fiq_win_n;
  logic              out_free;
  logic              accept;

  assign accept   = s_tvalid && s_tready;
  assign line_ok  = {1'b0, line} < (LINE_W + 1)'(NUM_LINES);
  assign cnt_last = cnt == IDX_W'(NUM_LINES - 1);
  assign out_free = !m_tvalid || m_tready;

  assign irq_win_n = (scan_pend && !irq_locked) ? irq_best : irq_winner;
  assign fiq_win_n = (scan_pend && !fiq_locked) ? fiq_best : fiq_winner;

  pic_line_table #(
    .NUM_LINES(NUM_LINES),
    .PRIO_BITS(PRIO_BITS)
  ) u_table (
    .clk(clk),
    .req(treq),
    .rd (trd)
  );

  pic_arbiter u_arb (
    .clk     (clk),
    .start   (state == ST_EXEC),
    .sample  (pv),
    .idx     (pidx),
    .rd      (trd),
    .irq_best(irq_best),
    .fiq_best(fiq_best)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table access
  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    treq            = '0;
    treq.waddr      = line;
    treq.act_wdata  = level;
    treq.fast_wdata = wfiq;
    treq.prio_wdata = wprio;
    treq.raddr      = line;
    unique case (state)
      ST_CLEAR: begin
        treq.act_we     = 1'b1;
        treq.cfg_we     = 1'b1;
        treq.waddr      = LINE_W'(cnt);
        treq.act_wdata  = 1'b0;
        treq.fast_wdata = 1'b0;
        treq.prio_wdata = '0;
        if (cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd)
          CMD_LEVEL: begin
            treq.act_we = line_ok;
            state_next  = ST_SCAN;
          end
          CMD_READ: begin
            if (regsel == REG_LINE_CFG && line_ok) state_next = ST_CFGRD;
            else state_next = ST_FINISH;
          end
          CMD_WRITE: begin
            treq.cfg_we = (regsel == REG_LINE_CFG) && line_ok;
            state_next  = ST_SCAN;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_CFGRD: state_next = ST_FINISH;
      ST_SCAN: begin
        treq.raddr = LINE_W'(cnt);
        if (cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Line counter for clearing and scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pv  <= 1'b0;
    end else begin
      pv <= (state == ST_SCAN);
      if (state == ST_CLEAR || state == ST_SCAN) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= LINE_W'(cnt);
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tuser[1:0];
      regsel <= s_tuser[4:2];
      line   <= s_tdata[7:0];
      level  <= s_tdata[8];
      wprio  <= s_tdata[16:9];
      wfiq   <= s_tdata[17];
      acknz  <= s_tdata[18];
    end
  end

  // Register decode, locks and response fields
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_locked <= 1'b0;
      fiq_locked <= 1'b0;
      scan_pend  <= 1'b0;
      irq_winner <= '0;
      fiq_winner <= '0;
    end else begin
      if (state == ST_EXEC) begin
        r_line    <= '0;
        r_unread  <= 1'b0;
        r_notack  <= 1'b0;
        r_prio    <= '0;
        r_fiq     <= 1'b0;
        r_id      <= '0;
        r_bad     <= 1'b0;
        scan_pend <= (cmd == CMD_LEVEL) || (cmd == CMD_WRITE);
        unique case (cmd)
          CMD_LEVEL: ;
          CMD_READ: begin
            unique case (regsel) inside
              REG_ID: r_id <= ID_VALUE;
              REG_FIQ_STAT: begin
                if (fiq_winner != '0) begin
                  r_unread <= !fiq_locked;
                  r_notack <= fiq_locked;
                  if (!fiq_locked) r_line <= fiq_winner;
                end
              end
              REG_IRQ_STAT: begin
                if (irq_winner != '0) begin
                  r_unread <= !irq_locked;
                  r_notack <= irq_locked;
                  if (!irq_locked) r_line <= irq_winner;
                end
              end
              REG_CUR_IRQ: begin
                if (irq_winner != '0 && !irq_locked) begin
                  r_line     <= irq_winner;
                  irq_locked <= 1'b1;
                end
              end
              REG_CUR_FIQ: begin
                if (fiq_winner != '0 && !fiq_locked) begin
                  r_line     <= fiq_winner;
                  fiq_locked <= 1'b1;
                end
              end
              REG_IRQ_ACK, REG_FIQ_ACK: r_bad <= 1'b1;
              REG_LINE_CFG: r_bad <= !line_ok;
            endcase
          end
          CMD_WRITE: begin
            unique case (regsel) inside
              REG_IRQ_STAT: ;
              REG_IRQ_ACK: if (acknz) irq_locked <= 1'b0;
              REG_FIQ_ACK: if (acknz) fiq_locked <= 1'b0;
              REG_LINE_CFG: r_bad <= !line_ok;
              REG_ID, REG_FIQ_STAT, REG_CUR_IRQ, REG_CUR_FIQ: r_bad <= 1'b1;
            endcase
          end
          default: r_bad <= 1'b1;
        endcase
      end
      if (state == ST_CFGRD) begin
        r_prio <= trd.prio;
        r_fiq  <= trd.fast;
      end
      // Commit the new winners once the scan is finished
      if (state == ST_FINISH) begin
        irq_winner <= irq_win_n;
        fiq_winner <= fiq_win_n;
        if (out_free) scan_pend <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {2'b00, r_bad,
                  !fiq_locked && (fiq_win_n != '0),
                  !irq_locked && (irq_win_n != '0),
                  r_id, r_fiq, r_prio, r_notack, r_unread, r_line};
    end
  end

`ifndef ASSERT_OFF
  // One request at a time: no accept right after an accept
  a_single_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while previous one in progress");

  // Locks never move during a table scan
  a_lock_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> ($stable(irq_locked) && $stable(fiq_locked)))
    else $error("class lock changed during scan");

  // Winners are only committed at the end of a request
  a_winner_commit: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> ($stable(irq_winner) && $stable(fiq_winner)))
    else $error("winner changed outside finish");

  // Scan samples stay inside the table
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    pv |-> ({1'b0, pidx} < (LINE_W + 1)'(NUM_LINES)))
    else $error("scan index out of range");

  // A response is loaded only into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && m_tvalid && !m_tready) |=> (state == ST_FINISH))
    else $error("finish left while output register busy");
`endif

endmodule

// ===== rtl/pic_line_table.sv =====
// ----------------------------------------------------------------------------
// pic_line_table
// Line table: level memory and config memory, both with registered read data.
// ----------------------------------------------------------------------------
module pic_line_table #(
  parameter int NUM_LINES = 170,
  parameter int PRIO_BITS = 8
) (
  input  logic              clk,
  input  pic_pkg::tbl_req_t req,
  output pic_pkg::tbl_rd_t  rd
);
  import pic_pkg::*;

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  logic                 act_mem  [NUM_LINES];
  logic [PRIO_BITS:0]   cfg_mem  [NUM_LINES];  // {fast, prio}
  logic                 act_q;
  logic [PRIO_BITS:0]   cfg_q;

  // Level memory
  always_ff @(posedge clk) begin
    if (req.act_we) begin
      act_mem[req.waddr[IDX_W-1:0]] <= req.act_wdata;
    end
    act_q <= act_mem[req.raddr[IDX_W-1:0]];
  end

  // Priority and class memory
  always_ff @(posedge clk) begin
    if (req.cfg_we) begin
      cfg_mem[req.waddr[IDX_W-1:0]] <= {req.fast_wdata, req.prio_wdata[PRIO_BITS-1:0]};
    end
    cfg_q <= cfg_mem[req.raddr[IDX_W-1:0]];
  end

  assign rd.active = act_q;
  assign rd.fast   = cfg_q[PRIO_BITS];
  assign rd.prio   = PRIO_W'(cfg_q[PRIO_BITS-1:0]);

endmodule

// ===== rtl/pic_arbiter.sv =====
// ----------------------------------------------------------------------------
// pic_arbiter
// Running best-line tracker for both classes over a sequential table scan.
// ----------------------------------------------------------------------------
module pic_arbiter (
  input  logic                      clk,
  input  logic                      start,
  input  logic                      sample,
  input  logic [pic_pkg::LINE_W-1:0] idx,
  input  pic_pkg::tbl_rd_t          rd,
  output logic [pic_pkg::LINE_W-1:0] irq_best,
  output logic [pic_pkg::LINE_W-1:0] fiq_best
);
  import pic_pkg::*;

  logic              irq_found;
  logic              fiq_found;
  logic [PRIO_W-1:0] irq_bprio;
  logic [PRIO_W-1:0] fiq_bprio;
  logic              irq_take;
  logic              fiq_take;

  // First hit wins, later hits only on strictly higher priority
  assign irq_take = sample && rd.active && !rd.fast && (!irq_found || rd.prio > irq_bprio);
  assign fiq_take = sample && rd.active && rd.fast && (!fiq_found || rd.prio > fiq_bprio);

  always_ff @(posedge clk) begin
    if (start) begin
      irq_found <= 1'b0;
      fiq_found <= 1'b0;
      irq_bprio <= '0;
      fiq_bprio <= '0;
      irq_best  <= '0;
      fiq_best  <= '0;
    end else begin
      if (irq_take) begin
        irq_found <= 1'b1;
        irq_bprio <= rd.prio;
        irq_best  <= idx;
      end
      if (fiq_take) begin
        fiq_found <= 1'b1;
        fiq_bprio <= rd.prio;
        fiq_best  <= idx;
      end
    end
  end

endmodule
